FILE: rtl/skim_pkg.sv
// skim_pkg: request and result types plus command and action codes for the
// sorted key table with duplicate merge. No dependencies.
package skim_pkg;

  localparam int unsigned KeyWidth = 32;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // action codes reported with each result
  localparam logic [1:0] ACT_NEW   = 2'd0;
  localparam logic [1:0] ACT_JOIN  = 2'd1;
  localparam logic [1:0] ACT_DROP  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  typedef struct packed {
    logic               command;
    logic [5:0]         member_id;
    logic signed [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] slot;
    logic [4:0] entry_count;
  } out_item_t;

endpackage

FILE: rtl/skim_store.sv
// skim_store: entry memory, one write port and one read port with a
// registered read. Holds key and member mask per entry. No dependencies.
module skim_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/skim_ctrl.sv
// skim_ctrl: sequencer that scans the sorted entries with one shared compare,
// merges or shifts entries up and places the new key. Uses skim_pkg, skim_store.
module skim_ctrl #(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned MEMBER_COUNT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  skim_pkg::in_item_t   in_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output skim_pkg::out_item_t  res_o
);
  import skim_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = KeyWidth + MEMBER_COUNT;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           wr_idx_q, wr_idx_d;
  logic                    pend_q, pend_d;
  logic signed [31:0]      key_q, key_d;
  logic [MEMBER_COUNT-1:0] mask_q, mask_d;
  out_item_t               res_q, res_d;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [EW-1:0]           wdata;
  logic [AW-1:0]           raddr;
  logic [EW-1:0]           rdata;
  logic signed [31:0]      rkey;
  logic [MEMBER_COUNT-1:0] rmask;
  logic [MEMBER_COUNT-1:0] in_bit;
  logic                    hit, key_lt, key_eq;
  logic [CW-1:0]           pos_inc, idx_dec;

  skim_store #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rkey  = rdata[EW-1 -: KeyWidth];
  assign rmask = rdata[MEMBER_COUNT-1:0];

  // one-hot member bit, ids beyond the mask set nothing
  always_comb begin
    for (int j = 0; j < MEMBER_COUNT; j++) begin
      in_bit[j] = (in_i.member_id == 6'(j));
    end
  end

  // shared compare unit: stored key against the request key
  assign hit     = (pos_q < count_q);
  assign key_lt  = (rkey < key_q);
  assign key_eq  = (rkey == key_q);
  assign pos_inc = pos_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    wr_idx_d = wr_idx_q;
    pend_d   = pend_q;
    key_d    = key_q;
    mask_d   = mask_q;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = pos_q[AW-1:0];
    wdata    = {key_q, mask_q};
    raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_i.command == CMD_CLEAR) begin
            count_d = '0;
            res_d   = '{action: ACT_CLEAR, slot: 4'd0, entry_count: 5'd0};
            state_d = S_DONE;
          end else begin
            key_d   = in_i.key;
            mask_d  = in_bit;
            pos_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit && key_lt) begin
          // next entry is read ahead while this one is compared
          pos_d = pos_inc;
          raddr = pos_inc[AW-1:0];
        end else if (hit && key_eq) begin
          we      = 1'b1;
          wdata   = {rkey, rmask | mask_q};
          res_d   = '{action: ACT_JOIN, slot: 4'(pos_q), entry_count: 5'(count_q)};
          state_d = S_DONE;
        end else if (count_q == CW'(TABLE_DEPTH)) begin
          res_d   = '{action: ACT_DROP, slot: 4'd0, entry_count: 5'(count_q)};
          state_d = S_DONE;
        end else begin
          idx_d   = count_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // read entry idx-1 while the previously read entry lands one slot up
        if (pend_q) begin
          we    = 1'b1;
          waddr = wr_idx_q;
          wdata = rdata;
        end
        if (idx_q != pos_q) begin
          raddr    = idx_dec[AW-1:0];
          wr_idx_d = idx_q[AW-1:0];
          pend_d   = 1'b1;
          idx_d    = idx_dec;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
        res_d   = '{action: ACT_NEW, slot: 4'(pos_q),
                    entry_count: 5'(count_q + CW'(1))};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    wr_idx_q <= wr_idx_d;
    key_q    <= key_d;
    mask_q   <= mask_d;
    res_q    <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

FILE: rtl/sorted_key_insert_with_merge.sv
// Sorted key table with duplicate merge. Keeps up to TABLE_DEPTH distinct
// signed Q16.16 keys in ascending order, each with a member mask. One request
// at a time: a clear only empties the count, while an insert scans the
// entries one entry per cycle through the single read port of the entry
// memory and ends in a join, in a drop on a full table, or for a new entry
// goes on with the one-entry-per-cycle shift of the entries above its slot
// and one write to place it. The result shows on the output in the same
// cycle in which the next request can be taken and then sits in an output
// register while it waits, so a stalled result only holds up the request
// after the next one. No clearing pass.
module sorted_key_insert_with_merge #(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned MEMBER_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skim_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skim_pkg::out_item_t out_o
);
  import skim_pkg::*;

  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_q;

  skim_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MEMBER_COUNT (MEMBER_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while a previous one is still in work");

  a_clear_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.action == ACT_CLEAR |->
      out_o.slot == 4'd0 && out_o.entry_count == 5'd0)
    else $error("clear result does not report an empty table");

  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.action == ACT_DROP |->
      out_o.slot == 4'd0 && out_o.entry_count == 5'(TABLE_DEPTH))
    else $error("drop result reported with table not full");

endmodule

FILE: dv/sorted_key_table_monitor.sv
`timescale 1ns / 100ps
// sorted_key_table_monitor: watches the request and result channels of the
// sorted key table, predicts every result and compares it. Needs skim_pkg.
module sorted_key_table_monitor #(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned MEMBER_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  skim_pkg::in_item_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  skim_pkg::out_item_t out_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  import skim_pkg::*;

  localparam int PrintLimit = 40;

  logic signed [KeyWidth-1:0] table_keys [TABLE_DEPTH];
  logic [63:0]                table_masks [TABLE_DEPTH];
  int unsigned                table_used;
  out_item_t                  expected_results [$];
  out_item_t                  oldest_expected;
  int                         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // updates the table copy with one request and returns the result it causes
  function automatic out_item_t predict_table_update(input in_item_t req);
    out_item_t   res;
    int unsigned pos;
    logic [63:0] member_bit;
    res = '0;
    if (req.command == CMD_CLEAR) begin
      table_used = 0;
      res.action = ACT_CLEAR;
    end else begin
      member_bit = (req.member_id < MEMBER_COUNT) ? (64'd1 << req.member_id) : 64'd0;
      pos = 0;
      while (pos < table_used && $signed(table_keys[pos]) < $signed(req.key)) pos++;
      if (pos < table_used && table_keys[pos] == req.key) begin
        table_masks[pos] |= member_bit;
        res.action = ACT_JOIN;
        res.slot   = 4'(pos);
      end else if (table_used >= TABLE_DEPTH) begin
        res.action = ACT_DROP;
      end else begin
        for (int unsigned i = table_used; i > pos; i--) begin
          table_keys[i]  = table_keys[i-1];
          table_masks[i] = table_masks[i-1];
        end
        table_keys[pos]  = req.key;
        table_masks[pos] = member_bit;
        table_used++;
        res.action = ACT_NEW;
        res.slot   = 4'(pos);
      end
    end
    res.entry_count = 5'(table_used);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_used = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // results first: a request taken at this edge cannot have answered yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: action %0d slot %0d count %0d",
                                    out_i.action, out_i.slot, out_i.entry_count));
        end else begin
          oldest_expected = expected_results.pop_front();
          if (out_i.action !== oldest_expected.action)
            report_mismatch($sformatf("action %0d, expected %0d",
                                      out_i.action, oldest_expected.action));
          if (out_i.slot !== oldest_expected.slot)
            report_mismatch($sformatf("slot %0d, expected %0d",
                                      out_i.slot, oldest_expected.slot));
          if (out_i.entry_count !== oldest_expected.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_i.entry_count, oldest_expected.entry_count));
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_table_update(in_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: dv/tb_sorted_key_insert_with_merge.sv
`timescale 1ns / 100ps
// tb_sorted_key_insert_with_merge: drives requests into the sorted key table
// and gives the verdict. Needs skim_pkg, the block and sorted_key_table_monitor.
module tb_sorted_key_insert_with_merge;
  import skim_pkg::*;

  localparam int unsigned TableDepth     = 16;
  localparam int unsigned MemberCount    = 64;
  localparam int          RandomRequests = 1630;
  localparam int          PoolSize       = 24;
  localparam int          IdleLimit      = 4000;
  localparam int          DrainCycles    = 40;

  logic      clk;
  logic      rst_n;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req;
  logic      res_valid;
  logic      res_stall;
  out_item_t res;
  int        pending;
  int        fail_count;
  int        sender_idle_pct = 0;
  int        stall_pct = 0;

  // keys reused often so that joins happen and the table fills up
  logic [31:0] key_pool [PoolSize];

  sorted_key_insert_with_merge #(
    .TABLE_DEPTH (TableDepth),
    .MEMBER_COUNT(MemberCount)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_i       (req),
    .out_valid_o(res_valid),
    .out_stall_i(res_stall),
    .out_o      (res)
  );

  sorted_key_table_monitor #(
    .TABLE_DEPTH (TableDepth),
    .MEMBER_COUNT(MemberCount)
  ) u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_i  (req_stall),
    .in_i        (req),
    .out_valid_i (res_valid),
    .out_stall_i (res_stall),
    .out_i       (res),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_item_t make_req(input logic cmd, input logic [5:0] id,
                                        input logic [31:0] k);
    in_item_t r;
    r.command   = cmd;
    r.member_id = id;
    r.key       = k;
    return r;
  endfunction

  function automatic void refill_key_pool();
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = $urandom_range(1) ? $urandom : 32'($signed($urandom) >>> 20);
    end
  endfunction

  function automatic in_item_t random_request();
    int unsigned pick;
    logic [31:0] k;
    pick = $urandom_range(99);
    if (pick < 3) begin
      refill_key_pool();
      return make_req(CMD_CLEAR, 6'($urandom), $urandom);
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      k = key_pool[$urandom_range(PoolSize-1)];
    end else if (pick < 75) begin
      k = $urandom;
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0:       k = 32'h8000_0000 + $urandom_range(3);
        1:       k = 32'h7FFF_FFFF - $urandom_range(3);
        default: k = 32'($urandom_range(4)) - 32'd2;
      endcase
    end else begin
      // neighbors of stored keys land between entries
      k = key_pool[$urandom_range(PoolSize-1)] + 32'($urandom_range(2)) - 32'd1;
    end
    return make_req(CMD_INSERT, 6'($urandom_range(63)), k);
  endfunction

  task automatic send_request(input in_item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    req_valid <= 1'b0;
    req       <= '0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, between, joins, full table, clear
    send_request(make_req(CMD_CLEAR, 6'($urandom), $urandom));
    send_request(make_req(CMD_INSERT, 6'd0, 32'h8000_0000));
    send_request(make_req(CMD_INSERT, 6'd63, 32'h7FFF_FFFF));
    send_request(make_req(CMD_INSERT, 6'd5, 32'h0000_0000));
    send_request(make_req(CMD_INSERT, 6'd5, 32'h0000_0000));
    send_request(make_req(CMD_INSERT, 6'd6, 32'h0000_0000));
    send_request(make_req(CMD_INSERT, 6'd1, 32'hFFFF_FFFF));
    send_request(make_req(CMD_INSERT, 6'd2, 32'h0000_0001));
    for (int i = 0; i < 10; i++) begin
      send_request(make_req(CMD_INSERT, 6'(i + 10), 32'(i + 2) << 16));
    end
    send_request(make_req(CMD_INSERT, 6'd40, 32'h0000_8000));
    send_request(make_req(CMD_INSERT, 6'd7, 32'h7FFF_FFFF));
    send_request(make_req(CMD_INSERT, 6'd63, 32'h8000_0001));
    send_request(make_req(CMD_CLEAR, 6'($urandom), $urandom));
    send_request(make_req(CMD_INSERT, 6'd33, 32'h8000_0000));

    refill_key_pool();
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_drain();
      case (phase)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 58; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 58; end
        default: begin sender_idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < RandomRequests / 4; n++) begin
        if ($urandom_range(99) == 0) wait_for_drain();
        send_request(random_request());
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
